// File: rtl/pbl_pkg.sv
// Shared types and constants of the price level book.
`timescale 1ns / 1ps
package pbl_pkg;

  localparam int MAX_LEVELS = 32;
  localparam int PRICE_BITS = 32;
  localparam int QTY_BITS   = 32;
  localparam int CNT_BITS   = $clog2(MAX_LEVELS + 1);

  typedef struct packed {
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
  } level_t;

  // update action for one side, valid only in the update cycle
  typedef struct packed {
    logic ins;
    logic del;
    logic rep;
  } pbl_ctl_t;

  typedef enum logic [2:0] {
    ST_REPLACED = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_INSERTED = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_DROPPED  = 3'd4
  } status_t;

endpackage

// File: rtl/price_level_book.sv
// Top level of the price level book: handshake, update sequencer, result register.
// The cells compare on the transfer edge; the row is updated and the result register
// loaded in state S_UPD, which waits while an earlier result is held and not drained.
// The cell row compares on the transfer in S_IDLE and shifts in S_UPD, so a new input
// is taken only once the row has been updated.
// A waiting result stalls the update state, and with it the next input transfer.
// Reset: synchronous active-low rst_n empties both sides and drops any pending result;
// level storage itself is not cleared, only entries below the depth are ever used.
`timescale 1ns / 1ps
module price_level_book import pbl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_side,
  input  logic [PRICE_BITS-1:0] in_price,
  input  logic [QTY_BITS-1:0]   in_quantity,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  output logic [PRICE_BITS-1:0] out_best_bid,
  output logic [PRICE_BITS-1:0] out_best_ask,
  output logic [PRICE_BITS:0]   out_mid_twice,
  output logic [CNT_BITS-1:0]   out_bid_depth,
  output logic [CNT_BITS-1:0]   out_ask_depth
);

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_t;

  state_t                state_r;
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [PRICE_BITS-1:0] out_best_bid_r, out_best_ask_r;
  logic [CNT_BITS-1:0]   out_bid_depth_r, out_ask_depth_r;

  // operation held between the compare and the update cycle
  logic                  op_side_r;
  logic [PRICE_BITS-1:0] op_price_r;
  logic [QTY_BITS-1:0]   op_qty_r;

  logic                  in_fire;
  logic                  upd_en;
  status_t               bid_status, ask_status;
  logic [PRICE_BITS-1:0] bid_best_nxt, ask_best_nxt;
  logic [CNT_BITS-1:0]   bid_cnt_nxt, ask_cnt_nxt;

  // accept only while no update is in flight; the cells compare on the transfer edge
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // apply the update once the result register is free or being drained
  assign upd_en = (state_r == S_UPD) && (!out_valid_r || out_ready);

  pbl_side u_bid (
    .clk       (clk),
    .rst_n     (rst_n),
    .is_ask    (1'b0),
    .cmp_en    (in_fire && !in_side),
    .cmp_price (in_price),
    .upd_en    (upd_en && !op_side_r),
    .upd_price (op_price_r),
    .upd_qty   (op_qty_r),
    .status    (bid_status),
    .best_nxt  (bid_best_nxt),
    .cnt_nxt   (bid_cnt_nxt)
  );

  pbl_side u_ask (
    .clk       (clk),
    .rst_n     (rst_n),
    .is_ask    (1'b1),
    .cmp_en    (in_fire && in_side),
    .cmp_price (in_price),
    .upd_en    (upd_en && op_side_r),
    .upd_price (op_price_r),
    .upd_qty   (op_qty_r),
    .status    (ask_status),
    .best_nxt  (ask_best_nxt),
    .cnt_nxt   (ask_cnt_nxt)
  );

  // operation payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_side_r  <= in_side;
      op_price_r <= in_price;
      op_qty_r   <= in_quantity;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) state_r <= S_UPD;
          if (out_ready) out_valid_r <= 1'b0;
        end
        S_UPD: begin
          if (upd_en) begin
            // load the result register from the post-update book
            state_r         <= S_IDLE;
            out_valid_r     <= 1'b1;
            out_status_r    <= op_side_r ? ask_status : bid_status;
            out_best_bid_r  <= bid_best_nxt;
            out_best_ask_r  <= ask_best_nxt;
            out_bid_depth_r <= bid_cnt_nxt;
            out_ask_depth_r <= ask_cnt_nxt;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_best_bid  = out_best_bid_r;
  assign out_best_ask  = out_best_ask_r;
  assign out_bid_depth = out_bid_depth_r;
  assign out_ask_depth = out_ask_depth_r;

  // twice the mid; zero when either best price reads as zero
  assign out_mid_twice = (out_best_bid_r == '0 || out_best_ask_r == '0) ? '0
                       : {1'b0, out_best_bid_r} + {1'b0, out_best_ask_r};

  a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_bid_depth_r <= CNT_BITS'(MAX_LEVELS)) &&
                    (out_ask_depth_r <= CNT_BITS'(MAX_LEVELS)))
    else $error("book depth above capacity");

  a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_UPD))
    else $error("result appeared without an update");

  a_empty_best: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_bid_depth_r == '0) |-> (out_best_bid_r == '0))
    else $error("empty bid side reports a best price");

  a_upd_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_UPD) && !in_ready)
    else $error("transfer did not start an update");

endmodule

// File: rtl/pbl_cell.sv
// One level cell: holds a price level, compares it to the update price, shifts.
`timescale 1ns / 1ps
module pbl_cell import pbl_pkg::*; (
  input  logic                  clk,
  input  logic                  is_ask,
  input  logic                  occupied,
  input  logic                  cmp_en,
  input  logic [PRICE_BITS-1:0] cmp_price,
  input  pbl_ctl_t              ctl,
  input  level_t                new_lvl,
  input  level_t                left_lvl,
  input  logic                  left_ahead,
  input  level_t                right_lvl,
  output level_t                lvl,
  output level_t                lvl_nxt,
  output logic                  ahead,
  output logic                  hit
);

  level_t lvl_r;
  logic   ahead_r, ahead_nxt;
  logic   hit_r, hit_nxt;

  // flags: this level is strictly better than the update price, or equal to it
  always_comb begin
    ahead_nxt = ahead_r;
    hit_nxt   = hit_r;
    if (cmp_en) begin
      hit_nxt   = occupied && (lvl_r.price == cmp_price);
      ahead_nxt = occupied && (is_ask ? (lvl_r.price < cmp_price)
                                      : (lvl_r.price > cmp_price));
    end
  end

  always_comb begin
    lvl_nxt = lvl_r;
    if (ctl.rep && hit_r) begin
      lvl_nxt.qty = new_lvl.qty;
    end
    // close the gap: every cell from the removed level on takes its right neighbor
    if (ctl.del && !ahead_r) begin
      lvl_nxt = right_lvl;
    end
    // open a slot: first cell not ahead takes the new level, the rest shift right
    if (ctl.ins && !ahead_r) begin
      lvl_nxt = left_ahead ? new_lvl : left_lvl;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r   <= lvl_nxt;
    ahead_r <= ahead_nxt;
    hit_r   <= hit_nxt;
  end

  assign lvl   = lvl_r;
  assign ahead = ahead_r;
  assign hit   = hit_r;

endmodule

// File: rtl/pbl_side.sv
// One book side: a row of level cells, its depth count and the update decode.
`timescale 1ns / 1ps
module pbl_side import pbl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  is_ask,
  input  logic                  cmp_en,
  input  logic [PRICE_BITS-1:0] cmp_price,
  input  logic                  upd_en,
  input  logic [PRICE_BITS-1:0] upd_price,
  input  logic [QTY_BITS-1:0]   upd_qty,
  output status_t               status,
  output logic [PRICE_BITS-1:0] best_nxt,
  output logic [CNT_BITS-1:0]   cnt_nxt
);

  logic [CNT_BITS-1:0]   cnt_r;
  logic [MAX_LEVELS-1:0] hit;
  logic [MAX_LEVELS-1:0] ahead;
  level_t                lvl     [MAX_LEVELS];
  level_t                lvl_nxt [MAX_LEVELS];
  level_t                new_lvl;
  pbl_ctl_t              ctl;
  logic                  any_hit, qty_zero, full;

  assign new_lvl.price = upd_price;
  assign new_lvl.qty   = upd_qty;
  assign any_hit  = |hit;
  assign qty_zero = (upd_qty == '0);
  assign full     = (cnt_r == CNT_BITS'(MAX_LEVELS));

  always_comb begin
    ctl     = '0;
    cnt_nxt = cnt_r;
    if (any_hit && qty_zero) begin
      status  = ST_REMOVED;
      ctl.del = upd_en;
      if (upd_en) cnt_nxt = cnt_r - CNT_BITS'(1);
    end else if (any_hit) begin
      status  = ST_REPLACED;
      ctl.rep = upd_en;
    end else if (qty_zero) begin
      status  = ST_IGNORED;
    end else if (full) begin
      status  = ST_DROPPED;
    end else begin
      status  = ST_INSERTED;
      ctl.ins = upd_en;
      if (upd_en) cnt_nxt = cnt_r + CNT_BITS'(1);
    end
  end

  assign best_nxt = (cnt_nxt == '0) ? '0 : lvl_nxt[0].price;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_cell
    level_t left_lvl, right_lvl;
    logic   left_ahead;
    if (i == 0) begin : g_head
      assign left_lvl   = new_lvl;
      assign left_ahead = 1'b1;
    end else begin : g_body
      assign left_lvl   = lvl[i-1];
      assign left_ahead = ahead[i-1];
    end
    if (i == MAX_LEVELS - 1) begin : g_tail
      assign right_lvl = lvl[i];
    end else begin : g_inner
      assign right_lvl = lvl[i+1];
    end

    pbl_cell u_cell (
      .clk        (clk),
      .is_ask     (is_ask),
      .occupied   (CNT_BITS'(i) < cnt_r),
      .cmp_en     (cmp_en),
      .cmp_price  (cmp_price),
      .ctl        (ctl),
      .new_lvl    (new_lvl),
      .left_lvl   (left_lvl),
      .left_ahead (left_ahead),
      .right_lvl  (right_lvl),
      .lvl        (lvl[i]),
      .lvl_nxt    (lvl_nxt[i]),
      .ahead      (ahead[i]),
      .hit        (hit[i])
    );
  end

endmodule
